FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/pilv_pkg.sv
package pilv_pkg;

   localparam int BUS_LINES_DEFAULT     = 8;
   localparam int LOCAL_SOURCES_DEFAULT = 8;
   localparam int LEVEL_COUNT           = 8;
   localparam int LEVEL_W               = $clog2(LEVEL_COUNT);

   // bus lines 0 and 1 both raise level 1
   localparam logic [7:0] SHARED_LEVEL1_LINES = 8'h03;

   localparam logic [LEVEL_W-1:0] LOCAL_LEVEL_LO = 3'd6;
   localparam logic [LEVEL_W-1:0] LOCAL_LEVEL_HI = 3'd7;

   typedef enum logic [1:0] {
      OP_BUS_LINE = 2'd0,
      OP_LOCAL    = 2'd1,
      OP_ENABLE   = 2'd2,
      OP_VECTOR   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_LEVEL6_MASK  = 2'd0,
      CSR_LEVEL7_MASK  = 2'd1,
      CSR_LOCAL_BASE   = 2'd2,
      CSR_BUS_BASE     = 2'd3
   } csr_index_type;

   typedef struct packed {
      opcode_type   opcode;
      logic [3:0]   line_index;
      logic         asserted;
      logic [2:0]   query_level;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]   irq_level;
      logic         level_changed;
      logic [7:0]   vector;
      logic         bad_line;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0]   level6_source_mask;
      logic [7:0]   level7_source_mask;
      logic [7:0]   local_vector_base;
      logic [7:0]   bus_vector_base;
   } csr_type;

endpackage

FILE: rtl/pilv_chan_if.sv
interface pilv_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/pilv_csr.sv
module pilv_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  pilv_pkg::csr_index_type csr_index,
   input  logic [7:0]             csr_write_data,
   output pilv_pkg::csr_type      csr
);
   import pilv_pkg::*;

   csr_type csr_ff;
   csr_type csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_LEVEL6_MASK: csr_in.level6_source_mask = csr_write_data;
            CSR_LEVEL7_MASK: csr_in.level7_source_mask = csr_write_data;
            CSR_LOCAL_BASE:  csr_in.local_vector_base  = csr_write_data;
            CSR_BUS_BASE:    csr_in.bus_vector_base    = csr_write_data;
            default:         csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;
endmodule

FILE: rtl/pilv_eval.sv
module pilv_eval #(
   parameter int BUS_LINES     = pilv_pkg::BUS_LINES_DEFAULT,
   parameter int LOCAL_SOURCES = pilv_pkg::LOCAL_SOURCES_DEFAULT
) (
   input  pilv_pkg::req_payload_type req,
   input  pilv_pkg::csr_type         csr,
   input  logic [BUS_LINES-1:0]      bus_ff,
   input  logic [LOCAL_SOURCES-1:0]  local_ff,
   input  logic                      enable_ff,
   input  logic [2:0]                level_ff,
   output logic [BUS_LINES-1:0]      bus_in,
   output logic [LOCAL_SOURCES-1:0]  local_in,
   output logic                      enable_in,
   output logic [2:0]                level_in,
   output pilv_pkg::rsp_payload_type rsp
);
   import pilv_pkg::*;

   logic       bus_bad;
   logic       local_bad;
   logic [7:0] bus8;
   logic [7:0] loc8;
   logic [7:0] pending;
   logic [2:0] top_level;
   logic [7:0] loc_now;
   logic [7:0] cand;
   logic [2:0] cand_idx;

   assign bus_bad   = req.line_index >= 4'(BUS_LINES);
   assign local_bad = req.line_index >= 4'(LOCAL_SOURCES);

   // line and enable update
   always_comb begin
      bus_in    = bus_ff;
      local_in  = local_ff;
      enable_in = enable_ff;
      case (req.opcode)
         OP_BUS_LINE: begin
            for (int i = 0; i < BUS_LINES; i++) begin
               if (req.line_index == 4'(i)) bus_in[i] = req.asserted;
            end
         end
         OP_LOCAL: begin
            for (int i = 0; i < LOCAL_SOURCES; i++) begin
               if (req.line_index == 4'(i)) local_in[i] = req.asserted;
            end
         end
         OP_ENABLE: enable_in = req.asserted;
         default:   enable_in = enable_ff;
      endcase
   end

   // pending levels after the update
   assign bus8 = 8'(bus_in);
   assign loc8 = 8'(local_in);

   always_comb begin
      pending      = {bus8[7:2], 2'b00};
      pending[1]   = |(bus8 & SHARED_LEVEL1_LINES);
      pending[6]   = pending[6] | (|(loc8 & csr.level6_source_mask));
      pending[7]   = pending[7] | (|(loc8 & csr.level7_source_mask));
      top_level    = '0;
      for (int i = 1; i < LEVEL_COUNT; i++) begin
         if (pending[i]) top_level = 3'(i);
      end
   end

   assign level_in = enable_in ? top_level : '0;

   // vector pick, lowest asserted local source wins
   assign loc_now = 8'(local_ff);

   always_comb begin
      if (req.query_level == LOCAL_LEVEL_LO) begin
         cand = loc_now & csr.level6_source_mask;
      end else if (req.query_level == LOCAL_LEVEL_HI) begin
         cand = loc_now & csr.level7_source_mask;
      end else begin
         cand = '0;
      end
      cand_idx = '0;
      for (int i = 7; i >= 0; i--) begin
         if (cand[i]) cand_idx = 3'(i);
      end
   end

   always_comb begin
      rsp.irq_level     = level_in;
      rsp.level_changed = level_in != level_ff;
      rsp.vector        = '0;
      rsp.bad_line      = 1'b0;
      case (req.opcode)
         OP_BUS_LINE: rsp.bad_line = bus_bad;
         OP_LOCAL:    rsp.bad_line = local_bad;
         OP_VECTOR: begin
            if (|cand) begin
               rsp.vector = csr.local_vector_base + 8'(cand_idx);
            end else begin
               rsp.vector = csr.bus_vector_base + 8'(req.query_level);
            end
         end
         default:     rsp.bad_line = 1'b0;
      endcase
   end
endmodule

FILE: rtl/priority_interrupt_level_and_vector_core.sv
// priority interrupt controller: level and vector
// a result beat is presented from the output register in the cycle after its request beat
// throughput: one request beat per cycle while result beats are taken, a waiting result beat
// holds off the request side until it drains, set by the single update and encode pass per beat
// reset (synchronous, active high) clears lines, enable, level, config and the output valid
module priority_interrupt_level_and_vector_core #(
   parameter int BUS_LINES     = pilv_pkg::BUS_LINES_DEFAULT,
   parameter int LOCAL_SOURCES = pilv_pkg::LOCAL_SOURCES_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   pilv_chan_if.sink               req_if,
   pilv_chan_if.source             rsp_if,
   input  logic                    csr_write_en,
   input  pilv_pkg::csr_index_type csr_index,
   input  logic [7:0]              csr_write_data
);
   import pilv_pkg::*;

   // config registers
   csr_type csr;

   // controller state
   logic [BUS_LINES-1:0]     bus_ff;
   logic [BUS_LINES-1:0]     bus_in;
   logic [LOCAL_SOURCES-1:0] local_ff;
   logic [LOCAL_SOURCES-1:0] local_in;
   logic                     enable_ff;
   logic                     enable_in;
   logic [2:0]               level_ff;
   logic [2:0]               level_in;

   // output register
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;

   logic req_beat;

   pilv_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .csr            (csr)
   );

   pilv_eval #(
      .BUS_LINES     (BUS_LINES),
      .LOCAL_SOURCES (LOCAL_SOURCES)
   ) u_eval (
      .req       (req_if.payload),
      .csr       (csr),
      .bus_ff    (bus_ff),
      .local_ff  (local_ff),
      .enable_ff (enable_ff),
      .level_ff  (level_ff),
      .bus_in    (bus_in),
      .local_in  (local_in),
      .enable_in (enable_in),
      .level_in  (level_in),
      .rsp       (rsp_data_in)
   );

   // take a new beat when the output register is empty or drains this cycle
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_beat     = req_if.valid && req_if.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_beat) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // state moves only on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff       <= '0;
         local_ff     <= '0;
         enable_ff    <= 1'b0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_beat) begin
            bus_ff    <= bus_in;
            local_ff  <= local_in;
            enable_ff <= enable_in;
            level_ff  <= level_in;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_beat) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;
endmodule

FILE: rtl/pilv_checker.sv
`include "assert_macros.svh"

module pilv_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input pilv_pkg::req_payload_type req_payload,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input pilv_pkg::rsp_payload_type rsp_payload
);
   import pilv_pkg::*;

   logic req_beat;
   logic stalled;

   assign req_beat = req_valid && req_ready;
   assign stalled  = rsp_valid && !rsp_ready;

   // a stalled result beat holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_valid && $stable(rsp_payload))

   // every accepted beat gives a result next cycle
   `ASSERT_NEXT(a_rsp_follows, clock, reset, req_beat, rsp_valid)

   // an empty output stage never blocks the request side
   `ASSERT_IMPLIES(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)

   // only queries carry a vector
   `ASSERT_NEXT(a_vector_zero, clock, reset,
      req_beat && req_payload.opcode != OP_VECTOR, rsp_payload.vector == 8'd0)

   // only line drives can be flagged bad
   `ASSERT_NEXT(a_bad_line_ops, clock, reset,
      req_beat && (req_payload.opcode == OP_ENABLE || req_payload.opcode == OP_VECTOR),
      !rsp_payload.bad_line)
endmodule

bind priority_interrupt_level_and_vector_core pilv_checker u_pilv_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .req_payload (req_if.payload),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);

FILE: sim/tb_priority_interrupt_level_and_vector_core.sv
module tb_priority_interrupt_level_and_vector_core;
   import pilv_pkg::*;

   // directed rows: the first DIR_SPLIT run with reset config, the rest after DIR_CFG
   localparam int DIR_ROWS        = 24;
   localparam int DIR_SPLIT       = 12;
   localparam int RAND_PHASES     = 6;
   localparam int PHASE_BEATS     = 75;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 8;
   localparam int CYCLE_LIMIT     = 120000;

   localparam csr_type DIR_CFG = '{
      level6_source_mask: 8'h0F,
      level7_source_mask: 8'hF0,
      local_vector_base:  8'hF8,
      bus_vector_base:    8'hFC
   };

   typedef struct {
      req_payload_type req;
      bit              typed;   // rsp holds a hand-written expectation
      rsp_payload_type rsp;
   } dir_row_type;

   logic            clock;
   logic            reset;
   logic            csr_write_en;
   csr_index_type   csr_index;
   logic [7:0]      csr_write_data;

   pilv_chan_if #(.payload_type(req_payload_type)) req_ch ();
   pilv_chan_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   priority_interrupt_level_and_vector_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_ch),
      .rsp_if         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // predictor state, mirrors the block
   csr_type         cfg;
   logic [7:0]      bus_pend;
   logic [7:0]      loc_pend;
   logic            irq_en;
   logic [2:0]      cur_level;

   rsp_payload_type outcome_q[$];
   dir_row_type     dir_tab[DIR_ROWS];
   int              errors;
   int              cycle_count;
   bit              calm;          // final stretch: no idling on either side
   bit              hold_off_req;  // asks the receiver for one long stall

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** priority_interrupt_level_and_vector_core: FAILED **");
         $finish;
      end
   end

   // next presented level and vector for one request beat, updates predictor state
   function automatic rsp_payload_type next_irq_outcome(req_payload_type p);
      rsp_payload_type r;
      logic [7:0]      pend;
      logic [7:0]      cand;
      logic [2:0]      prev;
      r    = '0;
      prev = cur_level;
      cand = '0;
      case (p.opcode)
         OP_BUS_LINE: begin
            // out-of-range line is flagged and changes nothing
            if (p.line_index >= BUS_LINES_DEFAULT) r.bad_line = 1'b1;
            else bus_pend[p.line_index] = p.asserted;
         end
         OP_LOCAL: begin
            if (p.line_index >= LOCAL_SOURCES_DEFAULT) r.bad_line = 1'b1;
            else loc_pend[p.line_index] = p.asserted;
         end
         OP_ENABLE: begin
            irq_en = p.asserted;
         end
         default: begin
            // query ignores enable; lowest asserting local source under the mask wins
            if (p.query_level == LOCAL_LEVEL_LO) cand = loc_pend & cfg.level6_source_mask;
            else if (p.query_level == LOCAL_LEVEL_HI) cand = loc_pend & cfg.level7_source_mask;
            r.vector = cfg.bus_vector_base + 8'(p.query_level);
            for (int i = LOCAL_SOURCES_DEFAULT - 1; i >= 0; i--)
               if (cand[i]) r.vector = cfg.local_vector_base + 8'(i);
         end
      endcase
      // bus lines 2..7 map to their own level, lines 0 and 1 share level 1
      pend = bus_pend & ~SHARED_LEVEL1_LINES;
      if (|(bus_pend & SHARED_LEVEL1_LINES)) pend[1] = 1'b1;
      if (|(loc_pend & cfg.level6_source_mask)) pend[LOCAL_LEVEL_LO] = 1'b1;
      if (|(loc_pend & cfg.level7_source_mask)) pend[LOCAL_LEVEL_HI] = 1'b1;
      cur_level = '0;
      if (irq_en)
         for (int i = 1; i < LEVEL_COUNT; i++)
            if (pend[i]) cur_level = 3'(i);
      r.irq_level     = cur_level;
      r.level_changed = (cur_level != prev);
      return r;
   endfunction

   function automatic dir_row_type drow(opcode_type op, logic [3:0] ln, logic a,
                                        logic [2:0] ql, bit typed, logic [2:0] lvl,
                                        logic ch, logic [7:0] vec, logic bad);
      dir_row_type d;
      d.req   = '{opcode: op, line_index: ln, asserted: a, query_level: ql};
      d.typed = typed;
      d.rsp   = '{irq_level: lvl, level_changed: ch, vector: vec, bad_line: bad};
      return d;
   endfunction

   // offer one beat, with an optional gap first, and log its expectation on acceptance
   task automatic send_beat(req_payload_type p, bit typed, rsp_payload_type want);
      rsp_payload_type pred;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= p;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pred = next_irq_outcome(p);
      outcome_q.push_back(typed ? want : pred);
   endtask

   // write all four registers once the block has drained
   task automatic load_csr(csr_type c);
      req_ch.valid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_LEVEL6_MASK;
      csr_write_data <= c.level6_source_mask;
      @(posedge clock);
      csr_index      <= CSR_LEVEL7_MASK;
      csr_write_data <= c.level7_source_mask;
      @(posedge clock);
      csr_index      <= CSR_LOCAL_BASE;
      csr_write_data <= c.local_vector_base;
      @(posedge clock);
      csr_index      <= CSR_BUS_BASE;
      csr_write_data <= c.bus_vector_base;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      cfg = c;
   endtask

   // result side: random stall bursts, one long hold-off on request
   initial begin : rsp_drive
      int stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (hold_off_req) begin
            // long stall so the block fills and backs up the request side
            hold_off_req = 1'b0;
            stall_left   = HOLD_OFF_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left   = $urandom_range(0, 10);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // result checker: each accepted beat against the oldest expectation
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (outcome_q.size() == 0) begin
            $display("%0t: result beat with nothing expected, actual %p", $time,
                     rsp_ch.payload);
            errors++;
         end else begin
            want = outcome_q.pop_front();
            if (rsp_ch.payload.irq_level !== want.irq_level) begin
               $display("%0t: irq_level expected %0d actual %0d", $time,
                        want.irq_level, rsp_ch.payload.irq_level);
               errors++;
            end
            if (rsp_ch.payload.level_changed !== want.level_changed) begin
               $display("%0t: level_changed expected %0d actual %0d", $time,
                        want.level_changed, rsp_ch.payload.level_changed);
               errors++;
            end
            if (rsp_ch.payload.vector !== want.vector) begin
               $display("%0t: vector expected %0h actual %0h", $time,
                        want.vector, rsp_ch.payload.vector);
               errors++;
            end
            if (rsp_ch.payload.bad_line !== want.bad_line) begin
               $display("%0t: bad_line expected %0d actual %0d", $time,
                        want.bad_line, rsp_ch.payload.bad_line);
               errors++;
            end
         end
      end
   end

   // stimulus
   initial begin : stim
      req_payload_type p;
      csr_type         c;
      int              pick;
      errors       = 0;
      cycle_count  = 0;
      calm         = 1'b0;
      hold_off_req = 1'b0;
      cfg          = '0;
      bus_pend     = '0;
      loc_pend     = '0;
      irq_en       = 1'b0;
      cur_level    = '0;

      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      csr_write_en   <= 1'b0;
      csr_index      <= CSR_LEVEL6_MASK;
      csr_write_data <= '0;

      // typed rows follow straight from reset config, or from DIR_CFG
      dir_tab = '{
         // reset config: every query gives the level itself
         drow(OP_VECTOR,   4'd0,  1'b0, 3'd0, 1, 3'd0, 1'b0, 8'h00, 1'b0),
         drow(OP_VECTOR,   4'd0,  1'b1, 3'd7, 1, 3'd0, 1'b0, 8'h07, 1'b0),
         // out-of-range lines on both kinds
         drow(OP_BUS_LINE, 4'd15, 1'b1, 3'd0, 1, 3'd0, 1'b0, 8'h00, 1'b1),
         drow(OP_LOCAL,    4'd8,  1'b1, 3'd0, 1, 3'd0, 1'b0, 8'h00, 1'b1),
         // disabled block presents nothing
         drow(OP_BUS_LINE, 4'd7,  1'b1, 3'd0, 1, 3'd0, 1'b0, 8'h00, 1'b0),
         drow(OP_ENABLE,   4'd0,  1'b1, 3'd0, 1, 3'd7, 1'b1, 8'h00, 1'b0),
         drow(OP_ENABLE,   4'd0,  1'b1, 3'd0, 1, 3'd7, 1'b0, 8'h00, 1'b0),
         drow(OP_BUS_LINE, 4'd7,  1'b0, 3'd0, 1, 3'd0, 1'b1, 8'h00, 1'b0),
         // lines 0 and 1 share level 1
         drow(OP_BUS_LINE, 4'd0,  1'b1, 3'd0, 1, 3'd1, 1'b1, 8'h00, 1'b0),
         drow(OP_BUS_LINE, 4'd1,  1'b1, 3'd0, 1, 3'd1, 1'b0, 8'h00, 1'b0),
         drow(OP_BUS_LINE, 4'd0,  1'b0, 3'd0, 1, 3'd1, 1'b0, 8'h00, 1'b0),
         drow(OP_BUS_LINE, 4'd1,  1'b0, 3'd0, 1, 3'd0, 1'b1, 8'h00, 1'b0),
         // DIR_CFG loaded here
         drow(OP_BUS_LINE, 4'd2,  1'b1, 3'd0, 0, 3'd0, 1'b0, 8'h00, 1'b0),
         drow(OP_LOCAL,    4'd3,  1'b1, 3'd0, 0, 3'd0, 1'b0, 8'h00, 1'b0),
         drow(OP_VECTOR,   4'd0,  1'b0, 3'd6, 1, 3'd6, 1'b0, 8'hFB, 1'b0),
         drow(OP_LOCAL,    4'd5,  1'b1, 3'd0, 0, 3'd0, 1'b0, 8'h00, 1'b0),
         drow(OP_VECTOR,   4'd0,  1'b0, 3'd7, 1, 3'd7, 1'b0, 8'hFD, 1'b0),
         // bus vector wraps past 255
         drow(OP_VECTOR,   4'd0,  1'b0, 3'd5, 1, 3'd7, 1'b0, 8'h01, 1'b0),
         drow(OP_LOCAL,    4'd0,  1'b1, 3'd0, 0, 3'd0, 1'b0, 8'h00, 1'b0),
         drow(OP_VECTOR,   4'd0,  1'b0, 3'd6, 0, 3'd0, 1'b0, 8'h00, 1'b0),
         drow(OP_ENABLE,   4'd0,  1'b0, 3'd0, 1, 3'd0, 1'b1, 8'h00, 1'b0),
         // query ignores the enable
         drow(OP_VECTOR,   4'd0,  1'b0, 3'd7, 1, 3'd0, 1'b0, 8'hFD, 1'b0),
         drow(OP_LOCAL,    4'd15, 1'b0, 3'd0, 1, 3'd0, 1'b0, 8'h00, 1'b1),
         drow(OP_BUS_LINE, 4'd8,  1'b0, 3'd0, 1, 3'd0, 1'b0, 8'h00, 1'b1)
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (i == DIR_SPLIT) load_csr(DIR_CFG);
         send_beat(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].rsp);
      end

      // random part: one register setting per phase, extremes first
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         if (ph == 0) c = '1;
         else if (ph == 1) c = '0;
         else c = '{level6_source_mask: 8'($urandom_range(0, 255)),
                    level7_source_mask: 8'($urandom_range(0, 255)),
                    local_vector_base:  8'($urandom_range(0, 255)),
                    bus_vector_base:    8'($urandom_range(0, 255))};
         // load_csr also makes the sender wait for every outstanding result
         load_csr(c);
         if (ph == 2) hold_off_req = 1'b1;
         if (ph == RAND_PHASES - 1) calm = 1'b1;
         for (int n = 0; n < PHASE_BEATS; n++) begin
            pick          = $urandom_range(0, 99);
            p.line_index  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
                                                         : 4'($urandom_range(0, 7));
            p.asserted    = 1'($urandom_range(0, 1));
            p.query_level = 3'($urandom_range(0, 7));
            if (pick < 35) begin
               p.opcode = OP_BUS_LINE;
            end else if (pick < 70) begin
               p.opcode = OP_LOCAL;
            end else if (pick < 80) begin
               // enable mostly on so levels get presented
               p.opcode   = OP_ENABLE;
               p.asserted = ($urandom_range(0, 3) != 0);
            end else begin
               p.opcode = OP_VECTOR;
               // lean queries toward the local levels
               if ($urandom_range(0, 1) == 0)
                  p.query_level = $urandom_range(0, 1) ? LOCAL_LEVEL_HI : LOCAL_LEVEL_LO;
            end
            send_beat(p, 1'b0, '0);
         end
      end

      req_ch.valid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("** priority_interrupt_level_and_vector_core: PASSED **");
      end else begin
         $display("** priority_interrupt_level_and_vector_core: FAILED **");
      end
      $finish;
   end

endmodule
